// ===== rtl/core/poisson_stencil_csr_generator_top_defines.svh =====
// Assertion macros used by the stencil generator top module.
`ifndef POISSON_STENCIL_CSR_GENERATOR_TOP_DEFINES_SVH
`define POISSON_STENCIL_CSR_GENERATOR_TOP_DEFINES_SVH

// Checked property, ignored while reset is asserted.
`define PSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked property that also holds across reset.
`define PSC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/core/psc_pkg.sv =====
package psc_pkg;

    // Grid geometry
    localparam int ROW_STRIDE = 64;
    localparam int MAX_ROWS   = 64;
    localparam int POS_W      = 6;
    localparam int SIZE_W     = 7;
    localparam int IDX_W      = 12;
    localparam int NNZ_W      = 15;
    localparam int COEF_W     = 32;
    localparam int VAL_W      = 34;
    localparam int SUM_W      = 35;
    localparam int SLOTS      = 5;
    localparam int CNT_W      = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Size limits; each cap is the smaller of 64 and the stride or row limit
    localparam logic [SIZE_W-1:0] MIN_SIZE   = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] WIDTH_CAP  = SIZE_W'(ROW_STRIDE < 64 ? ROW_STRIDE : 64);
    localparam logic [SIZE_W-1:0] HEIGHT_CAP = SIZE_W'(MAX_ROWS < 64 ? MAX_ROWS : 64);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_MODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_SOUTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_WEST     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_EAST     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_NORTH    = 3'd7;

    // Entry slots in emit order
    localparam int SLOT_S = 0;
    localparam int SLOT_W = 1;
    localparam int SLOT_C = 2;
    localparam int SLOT_E = 3;
    localparam int SLOT_N = 4;

    // Boundary modes
    localparam logic MODE_DIRICHLET = 1'b0;
    localparam logic MODE_NEUMANN   = 1'b1;

    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic              mode;
        logic [COEF_W-1:0] south;
        logic [COEF_W-1:0] west;
        logic [COEF_W-1:0] center;
        logic [COEF_W-1:0] east;
        logic [COEF_W-1:0] north;
    } cfg_t;

    typedef struct packed {
        logic [SLOTS-1:0] mask;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] me;
        logic [VAL_W-1:0] center_val;
        logic             east;
        logic             done;
    } point_t;

    // Sign-extend a coefficient to entry width
    function automatic logic [VAL_W-1:0] sext_val(input logic [COEF_W-1:0] c);
        sext_val = {{(VAL_W-COEF_W){c[COEF_W-1]}}, c};
    endfunction

endpackage

// ===== rtl/core/poisson_stencil_csr_generator_top.sv =====
// Five-point stencil matrix generator, compressed sparse row form.
// Input channel s_*: one transfer per grid point; s_restart = 1 starts a
// new matrix at grid point zero. Points are walked column by column, then
// row by row; after the last point the walk returns to point zero by itself.
// Result channel m_*: 3 to 5 entries per point, in the order south, west,
// center, east, north; m_last_of_row marks the point's last entry and
// m_grid_done is set on every entry of the grid's last point.
// Config port: cfg_wr_en writes cfg_wdata into register cfg_index; write
// only while no point is in flight. The first entry of a point passes
// through the pending-slot register, then the output register. Entries
// leave the output register one per cycle while the receiver is ready.
// The next point is taken while the previous one's last entry is being
// loaded or still waits.
// Reset (aresetn low, synchronous): position and count clear, width and
// height return to 64, Dirichlet mode, all coefficients zero, no results.
// When the receiver stalls the output register holds its entry, the
// pending point waits, and s_ready falls once that point is queued.
`include "poisson_stencil_csr_generator_top_defines.svh"

module poisson_stencil_csr_generator_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [psc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [psc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // grid point input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_restart,
    // matrix entries
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [psc_pkg::IDX_W-1:0]         m_row_index,
    output logic [psc_pkg::NNZ_W-1:0]         m_row_start,
    output logic [psc_pkg::IDX_W-1:0]         m_column,
    output logic signed [psc_pkg::VAL_W-1:0]  m_value,
    output logic [psc_pkg::NNZ_W-1:0]         m_next_row_start,
    output logic                              m_last_of_row,
    output logic                              m_grid_done
);

    psc_pkg::cfg_t               cfg_reg;
    logic [psc_pkg::POS_W-1:0]   col_pos_reg;
    logic [psc_pkg::POS_W-1:0]   row_pos_reg;
    logic [psc_pkg::NNZ_W-1:0]   nnz_reg;

    logic [psc_pkg::SLOTS-1:0]   pend_reg;
    logic [psc_pkg::SLOTS-1:0]   pend_next;
    logic [psc_pkg::IDX_W-1:0]   me_reg;
    logic [psc_pkg::NNZ_W-1:0]   start_reg;
    logic [psc_pkg::NNZ_W-1:0]   next_reg;
    logic [psc_pkg::VAL_W-1:0]   center_reg;
    logic                        done_reg;

    logic                        out_valid_reg;
    logic [psc_pkg::IDX_W-1:0]   out_row_reg;
    logic [psc_pkg::NNZ_W-1:0]   out_start_reg;
    logic [psc_pkg::IDX_W-1:0]   out_col_reg;
    logic [psc_pkg::VAL_W-1:0]   out_val_reg;
    logic [psc_pkg::NNZ_W-1:0]   out_next_reg;
    logic                        out_last_reg;
    logic                        out_done_reg;

    logic [psc_pkg::POS_W-1:0]   col_eff;
    logic [psc_pkg::POS_W-1:0]   row_eff;
    logic [psc_pkg::NNZ_W-1:0]   nnz_eff;
    logic [psc_pkg::NNZ_W-1:0]   nnz_after;
    psc_pkg::point_t             pt;

    logic                        s_accept;
    logic                        out_load;
    logic                        emit;
    logic [psc_pkg::SLOTS-1:0]   sel_oh;
    logic [psc_pkg::SLOTS-1:0]   pend_clr;
    logic [psc_pkg::IDX_W-1:0]   emit_col;
    logic [psc_pkg::VAL_W-1:0]   emit_val;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width  <= psc_pkg::SIZE_W'(64);
            cfg_reg.height <= psc_pkg::SIZE_W'(64);
            cfg_reg.mode   <= psc_pkg::MODE_DIRICHLET;
            cfg_reg.south  <= '0;
            cfg_reg.west   <= '0;
            cfg_reg.center <= '0;
            cfg_reg.east   <= '0;
            cfg_reg.north  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                psc_pkg::REG_GRID_WIDTH:    cfg_reg.width  <= cfg_wdata[psc_pkg::SIZE_W-1:0];
                psc_pkg::REG_GRID_HEIGHT:   cfg_reg.height <= cfg_wdata[psc_pkg::SIZE_W-1:0];
                psc_pkg::REG_BOUNDARY_MODE: cfg_reg.mode   <= cfg_wdata[0];
                psc_pkg::REG_COEF_SOUTH:    cfg_reg.south  <= cfg_wdata;
                psc_pkg::REG_COEF_WEST:     cfg_reg.west   <= cfg_wdata;
                psc_pkg::REG_COEF_CENTER:   cfg_reg.center <= cfg_wdata;
                psc_pkg::REG_COEF_EAST:     cfg_reg.east   <= cfg_wdata;
                psc_pkg::REG_COEF_NORTH:    cfg_reg.north  <= cfg_wdata;
            endcase
        end
    end

    // Restart clears position and count ahead of the stencil
    assign col_eff = s_restart ? '0 : col_pos_reg;
    assign row_eff = s_restart ? '0 : row_pos_reg;
    assign nnz_eff = s_restart ? '0 : nnz_reg;

    psc_stencil u_stencil (
        .cfg     (cfg_reg),
        .col_pos (col_eff),
        .row_pos (row_eff),
        .pt      (pt)
    );

    assign nnz_after = nnz_eff + psc_pkg::NNZ_W'(pt.count);

    // Entry sequencing: lowest pending slot goes out first
    assign out_load = !out_valid_reg || m_ready;
    assign emit     = out_load && (pend_reg != '0);
    assign sel_oh   = pend_reg & (~pend_reg + 1'b1);
    assign pend_clr = pend_reg & ~sel_oh;
    assign s_ready  = (pend_reg == '0) || (emit && (pend_clr == '0));
    assign s_accept = s_valid && s_ready;

    always_comb begin
        priority if (s_accept) begin
            pend_next = pt.mask;
        end else if (emit) begin
            pend_next = pend_clr;
        end else begin
            pend_next = pend_reg;
        end
    end

    // Column and value of the selected slot
    always_comb begin
        priority if (sel_oh[psc_pkg::SLOT_S]) begin
            emit_col = me_reg - psc_pkg::IDX_W'(psc_pkg::ROW_STRIDE);
            emit_val = psc_pkg::sext_val(cfg_reg.south);
        end else if (sel_oh[psc_pkg::SLOT_W]) begin
            emit_col = me_reg - 1'b1;
            emit_val = psc_pkg::sext_val(cfg_reg.west);
        end else if (sel_oh[psc_pkg::SLOT_C]) begin
            emit_col = me_reg;
            emit_val = center_reg;
        end else if (sel_oh[psc_pkg::SLOT_E]) begin
            emit_col = me_reg + 1'b1;
            emit_val = psc_pkg::sext_val(cfg_reg.east);
        end else begin
            emit_col = me_reg + psc_pkg::IDX_W'(psc_pkg::ROW_STRIDE);
            emit_val = psc_pkg::sext_val(cfg_reg.north);
        end
    end

    // Walk state and pending-point control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            nnz_reg     <= '0;
            pend_reg    <= '0;
        end else begin
            pend_reg <= pend_next;
            if (s_accept) begin
                if (pt.done) begin
                    col_pos_reg <= '0;
                    row_pos_reg <= '0;
                    nnz_reg     <= '0;
                end else if (!pt.east) begin
                    col_pos_reg <= '0;
                    row_pos_reg <= row_eff + 1'b1;
                    nnz_reg     <= nnz_after;
                end else begin
                    col_pos_reg <= col_eff + 1'b1;
                    row_pos_reg <= row_eff;
                    nnz_reg     <= nnz_after;
                end
            end
        end
    end

    // Pending point payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            me_reg     <= pt.me;
            start_reg  <= nnz_eff;
            next_reg   <= nnz_after;
            center_reg <= pt.center_val;
            done_reg   <= pt.done;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_row_reg   <= me_reg;
            out_start_reg <= start_reg;
            out_col_reg   <= emit_col;
            out_val_reg   <= emit_val;
            out_next_reg  <= next_reg;
            out_last_reg  <= (pend_clr == '0);
            out_done_reg  <= done_reg;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_row_index      = out_row_reg;
    assign m_row_start      = out_start_reg;
    assign m_column         = out_col_reg;
    assign m_value          = out_val_reg;
    assign m_next_row_start = out_next_reg;
    assign m_last_of_row    = out_last_reg;
    assign m_grid_done      = out_done_reg;

    // Checks
    `PSC_ASSERT(a_ready_one_left, s_ready |-> $countones(pend_reg) <= 1, "input ready with entries left")
    `PSC_ASSERT(a_center_queued, s_accept |=> pend_reg[psc_pkg::SLOT_C], "point queued without center")
    `PSC_ASSERT(a_last_flag, (emit && (pend_clr == '0)) |=> (m_valid && m_last_of_row), "last entry not flagged")
    `PSC_ASSERT_RST(a_reset_clear, !aresetn |=> ((pend_reg == '0) && !m_valid), "reset left work pending")

endmodule

// ===== rtl/core/psc_stencil.sv =====
module psc_stencil (
    input  psc_pkg::cfg_t                 cfg,
    input  logic [psc_pkg::POS_W-1:0]     col_pos,
    input  logic [psc_pkg::POS_W-1:0]     row_pos,
    output psc_pkg::point_t               pt
);

    logic [psc_pkg::POS_W-1:0] wlast;
    logic [psc_pkg::POS_W-1:0] hlast;
    logic                      south;
    logic                      west;
    logic                      east;
    logic                      north;
    logic [psc_pkg::SUM_W-1:0] a1;
    logic [psc_pkg::SUM_W-1:0] a2;
    logic [psc_pkg::SUM_W-1:0] a3;
    logic [psc_pkg::SUM_W-1:0] a4;
    logic [psc_pkg::SUM_W-1:0] a5;
    logic [psc_pkg::SUM_W-1:0] folded;
    logic [psc_pkg::SUM_W-1:0] center_sum;

    // Last column / row index after clamping the size registers
    always_comb begin
        priority if (cfg.width < psc_pkg::MIN_SIZE) begin
            wlast = psc_pkg::POS_W'(psc_pkg::MIN_SIZE - 1'b1);
        end else if (cfg.width > psc_pkg::WIDTH_CAP) begin
            wlast = psc_pkg::POS_W'(psc_pkg::WIDTH_CAP - 1'b1);
        end else begin
            wlast = psc_pkg::POS_W'(cfg.width - 1'b1);
        end
    end

    always_comb begin
        priority if (cfg.height < psc_pkg::MIN_SIZE) begin
            hlast = psc_pkg::POS_W'(psc_pkg::MIN_SIZE - 1'b1);
        end else if (cfg.height > psc_pkg::HEIGHT_CAP) begin
            hlast = psc_pkg::POS_W'(psc_pkg::HEIGHT_CAP - 1'b1);
        end else begin
            hlast = psc_pkg::POS_W'(cfg.height - 1'b1);
        end
    end

    // Neighbor presence; positions past the edge count as the edge
    assign south = (row_pos != '0);
    assign west  = (col_pos != '0);
    assign east  = (col_pos < wlast);
    assign north = (row_pos < hlast);

    assign a1 = {{(psc_pkg::SUM_W-psc_pkg::COEF_W){cfg.south[psc_pkg::COEF_W-1]}}, cfg.south};
    assign a2 = {{(psc_pkg::SUM_W-psc_pkg::COEF_W){cfg.west[psc_pkg::COEF_W-1]}}, cfg.west};
    assign a3 = {{(psc_pkg::SUM_W-psc_pkg::COEF_W){cfg.center[psc_pkg::COEF_W-1]}}, cfg.center};
    assign a4 = {{(psc_pkg::SUM_W-psc_pkg::COEF_W){cfg.east[psc_pkg::COEF_W-1]}}, cfg.east};
    assign a5 = {{(psc_pkg::SUM_W-psc_pkg::COEF_W){cfg.north[psc_pkg::COEF_W-1]}}, cfg.north};

    // Fold missing neighbors into the diagonal
    assign folded = (south ? '0 : a1) + (west ? '0 : a2)
                  + (east  ? '0 : a4) + (north ? '0 : a5);
    assign center_sum = (cfg.mode == psc_pkg::MODE_NEUMANN) ? (a3 + folded) : (a3 - folded);

    always_comb begin
        pt.mask                 = '0;
        pt.mask[psc_pkg::SLOT_S] = south;
        pt.mask[psc_pkg::SLOT_W] = west;
        pt.mask[psc_pkg::SLOT_C] = 1'b1;
        pt.mask[psc_pkg::SLOT_E] = east;
        pt.mask[psc_pkg::SLOT_N] = north;
        pt.count      = psc_pkg::CNT_W'(1) + psc_pkg::CNT_W'(south) + psc_pkg::CNT_W'(west)
                      + psc_pkg::CNT_W'(east) + psc_pkg::CNT_W'(north);
        pt.me         = psc_pkg::IDX_W'(row_pos) * psc_pkg::IDX_W'(psc_pkg::ROW_STRIDE)
                      + psc_pkg::IDX_W'(col_pos);
        pt.center_val = center_sum[psc_pkg::VAL_W-1:0];
        pt.east       = east;
        pt.done       = !north && !east;
    end

endmodule

// ===== bench/stencil_entry_checker.sv =====
module stencil_entry_checker
    import psc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic                     s_restart,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [IDX_W-1:0]         m_row_index,
    input  logic [NNZ_W-1:0]         m_row_start,
    input  logic [IDX_W-1:0]         m_column,
    input  logic signed [VAL_W-1:0]  m_value,
    input  logic [NNZ_W-1:0]         m_next_row_start,
    input  logic                     m_last_of_row,
    input  logic                     m_grid_done,
    output int                       mismatch_count,
    output int                       entries_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [IDX_W-1:0] row_index;
        logic [NNZ_W-1:0] row_start;
        logic [IDX_W-1:0] column;
        logic [VAL_W-1:0] value;
        logic [NNZ_W-1:0] next_row_start;
        logic             last_of_row;
        logic             grid_done;
    } csr_entry_t;

    csr_entry_t entry_q[$];
    csr_entry_t want;

    // Shadow copy of the register file
    logic [SIZE_W-1:0] grid_w, grid_h;
    logic              fold_mode;
    logic [COEF_W-1:0] k_south, k_west, k_center, k_east, k_north;

    // Walk position and running nonzero count
    logic [POS_W-1:0]  col_pos, row_pos;
    logic [NNZ_W-1:0]  nnz;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] cap);
        if (v < MIN_SIZE) return MIN_SIZE;
        if (v > cap) return cap;
        return v;
    endfunction

    // Expand one grid point into its S, W, C, E, N entries
    function automatic void expand_point(input logic restart);
        logic [SIZE_W-1:0] w, h;
        logic              south, west, east, north, done;
        int                me, n;
        longint            a1, a2, a3, a4, a5, folded, center;
        int                cols[SLOTS];
        longint            vals[SLOTS];
        logic [NNZ_W-1:0]  start;
        csr_entry_t        e;

        if (restart) begin
            col_pos = '0;
            row_pos = '0;
            nnz     = '0;
        end
        w = clamp_size(grid_w, WIDTH_CAP);
        h = clamp_size(grid_h, HEIGHT_CAP);
        a1 = longint'($signed(k_south));
        a2 = longint'($signed(k_west));
        a3 = longint'($signed(k_center));
        a4 = longint'($signed(k_east));
        a5 = longint'($signed(k_north));

        // positions past the edge count as the edge
        south = row_pos > 0;
        north = row_pos < h - 1;
        west  = col_pos > 0;
        east  = col_pos < w - 1;
        done  = !north && !east;
        me    = int'(row_pos) * ROW_STRIDE + int'(col_pos);

        n = 0;
        folded = 0;
        if (south) begin
            cols[n] = me - ROW_STRIDE; vals[n] = a1; n++;
        end else folded += a1;
        if (west) begin
            cols[n] = me - 1; vals[n] = a2; n++;
        end else folded += a2;
        if (!east)  folded += a4;
        if (!north) folded += a5;
        center = (fold_mode == MODE_NEUMANN) ? a3 + folded : a3 - folded;
        cols[n] = me; vals[n] = center; n++;
        if (east) begin
            cols[n] = me + 1; vals[n] = a4; n++;
        end
        if (north) begin
            cols[n] = me + ROW_STRIDE; vals[n] = a5; n++;
        end

        start = nnz;
        nnz   = NNZ_W'(nnz + n);
        for (int k = 0; k < n; k++) begin
            e.row_index      = IDX_W'(me);
            e.row_start      = start;
            e.column         = IDX_W'(cols[k]);
            e.value          = VAL_W'(vals[k]);
            e.next_row_start = nnz;
            e.last_of_row    = (k == n - 1);
            e.grid_done      = done;
            entry_q.push_back(e);
        end

        // advance the walk; wrap to point zero after the last point
        if (done) begin
            col_pos = '0;
            row_pos = '0;
            nnz     = '0;
        end else if (!east) begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endfunction

    function automatic void check_field(input string field, input logic [63:0] exp_v,
                                        input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            if (mismatch_count < 25)
                $error("%s: expected %0h, got %0h", field, exp_v, got_v);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            grid_w    = 7'd64;
            grid_h    = 7'd64;
            fold_mode = MODE_DIRICHLET;
            k_south   = '0;
            k_west    = '0;
            k_center  = '0;
            k_east    = '0;
            k_north   = '0;
            col_pos   = '0;
            row_pos   = '0;
            nnz       = '0;
            mismatch_count = 0;
            entry_q.delete();
        end else begin
            // register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_GRID_WIDTH:    grid_w    = cfg_wdata[SIZE_W-1:0];
                    REG_GRID_HEIGHT:   grid_h    = cfg_wdata[SIZE_W-1:0];
                    REG_BOUNDARY_MODE: fold_mode = cfg_wdata[0];
                    REG_COEF_SOUTH:    k_south   = cfg_wdata;
                    REG_COEF_WEST:     k_west    = cfg_wdata;
                    REG_COEF_CENTER:   k_center  = cfg_wdata;
                    REG_COEF_EAST:     k_east    = cfg_wdata;
                    REG_COEF_NORTH:    k_north   = cfg_wdata;
                    default: ;
                endcase
            end

            // point transfer in
            if (s_valid && s_ready)
                expand_point(s_restart);

            // entry transfer out
            if (m_valid && m_ready) begin
                if (entry_q.size() == 0) begin
                    if (mismatch_count < 25)
                        $error("entry at row %0d with no point outstanding", m_row_index);
                    mismatch_count++;
                end else begin
                    want = entry_q.pop_front();
                    check_field("row_index", want.row_index, m_row_index);
                    check_field("row_start", want.row_start, m_row_start);
                    check_field("column", want.column, m_column);
                    check_field("value", want.value, $unsigned(m_value));
                    check_field("next_row_start", want.next_row_start, m_next_row_start);
                    check_field("last_of_row", want.last_of_row, m_last_of_row);
                    check_field("grid_done", want.grid_done, m_grid_done);
                end
            end
        end
        entries_due = entry_q.size();
    end

endmodule

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import psc_pkg::*;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
    logic                     s_valid = 1'b0;
    logic                     s_restart = 1'b0;
    logic                     m_ready = 1'b0;
    logic                     s_ready;
    logic                     m_valid;
    logic [IDX_W-1:0]         m_row_index;
    logic [NNZ_W-1:0]         m_row_start;
    logic [IDX_W-1:0]         m_column;
    logic signed [VAL_W-1:0]  m_value;
    logic [NNZ_W-1:0]         m_next_row_start;
    logic                     m_last_of_row;
    logic                     m_grid_done;

    int mismatch_count;
    int entries_due;
    bit quiet = 1'b0;

    poisson_stencil_csr_generator_top dut (
        .aclk, .aresetn,
        .cfg_wr_en, .cfg_index, .cfg_wdata,
        .s_valid, .s_ready, .s_restart,
        .m_valid, .m_ready, .m_row_index, .m_row_start, .m_column, .m_value,
        .m_next_row_start, .m_last_of_row, .m_grid_done
    );

    stencil_entry_checker u_checker (
        .aclk, .aresetn,
        .cfg_wr_en, .cfg_index, .cfg_wdata,
        .s_valid, .s_ready, .s_restart,
        .m_valid, .m_ready, .m_row_index, .m_row_start, .m_column, .m_value,
        .m_next_row_start, .m_last_of_row, .m_grid_done,
        .mismatch_count, .entries_due
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Receiver backpressure: random stall bursts, none once quiet
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (quiet) begin
                m_ready <= 1'b1;
            end else if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else if ($urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                hold = $urandom_range(0, 4);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Generous run limit
    initial begin
        #400_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
    endtask

    task automatic set_grid(input logic [31:0] w, input logic [31:0] h, input logic [31:0] mode,
                            input logic [31:0] ks, input logic [31:0] kw, input logic [31:0] kc,
                            input logic [31:0] ke, input logic [31:0] kn);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        write_reg(REG_BOUNDARY_MODE, mode);
        write_reg(REG_COEF_SOUTH, ks);
        write_reg(REG_COEF_WEST, kw);
        write_reg(REG_COEF_CENTER, kc);
        write_reg(REG_COEF_EAST, ke);
        write_reg(REG_COEF_NORTH, kn);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // One point transfer; valid stays up for a following point
    task automatic send_point(input logic restart);
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_restart <= restart;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge aclk);
        s_valid   <= 1'b0;
        s_restart <= $urandom_range(0, 1);
        repeat (cycles - 1) @(negedge aclk);
    endtask

    // Hold off until every outstanding entry has been taken
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (entries_due != 0) @(negedge aclk);
    endtask

    task automatic feed(input int count, input bit first_restart, input int restart_odds);
        for (int i = 0; i < count; i++) begin
            if (!quiet && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 5));
            if (!quiet && $urandom_range(0, 39) == 0)
                drain();
            if (i == 0 && first_restart)
                send_point(1'b1);
            else
                send_point(restart_odds > 0 && $urandom_range(0, restart_odds - 1) == 0);
        end
    endtask

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_size(input int hi);
        if ($urandom_range(0, 4) == 0) return $urandom;
        return $urandom_range(2, hi);
    endfunction

    initial begin
        int count;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // reset register values: 64x64 grid, zero coefficients
        feed(2, 1'b0, 0);

        // 2x2 grid, every point a corner, wrap back to point zero
        drain();
        set_grid(2, 2, MODE_DIRICHLET, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000);
        feed(5, 1'b1, 0);

        // Neumann with all coefficients at the negative extreme, restart mid-grid
        drain();
        set_grid(2, 2, MODE_NEUMANN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000);
        send_point(1'b0);
        send_point(1'b0);
        send_point(1'b1);
        send_point(1'b0);
        send_point(1'b0);

        // out-of-range sizes get clamped
        drain();
        set_grid(0, 127, MODE_DIRICHLET, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        feed(2, 1'b1, 0);
        drain();
        set_grid(127, 1, MODE_NEUMANN, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFC_0000,
                 32'h0001_0000, 32'hFFFF_FFFF);
        feed(2, 1'b1, 0);

        // shrink the grid under the walk: position lands past the last column, on the last row
        drain();
        set_grid(8, 8, MODE_DIRICHLET, 32'h0001_0000, 32'h0002_0000, 32'hFFF0_0000,
                 32'h0003_0000, 32'h0004_0000);
        feed(10, 1'b1, 0);
        drain();
        set_grid(2, 2, MODE_NEUMANN, 32'h0001_0000, 32'h0002_0000, 32'hFFF0_0000,
                 32'h0003_0000, 32'h0004_0000);
        feed(2, 1'b0, 0);

        // random phases; mostly small grids, one full-width walk
        for (int phase = 0; phase < 12; phase++) begin
            drain();
            if (phase == 10) quiet = 1'b1;
            if (phase == 3) begin
                set_grid(64, $urandom_range(2, 3), $urandom_range(0, 1), pick_coef(),
                         pick_coef(), pick_coef(), pick_coef(), pick_coef());
                feed(70, 1'b1, 0);
            end else begin
                set_grid(pick_size(8), pick_size(6), $urandom, pick_coef(), pick_coef(),
                         pick_coef(), pick_coef(), pick_coef());
                count = $urandom_range(6, 14);
                feed(count, 1'b0, 12);
            end
        end

        drain();
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
